### hdl/cogging_torque_compensation_lut_defines.svh
// Assertion macros for the cogging compensation RTL.
`ifndef COGGING_TORQUE_COMPENSATION_LUT_DEFINES_SVH
`define COGGING_TORQUE_COMPENSATION_LUT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define CTCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define CTCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ctcl_pkg.sv
// Shared constants and types of the cogging compensation lookup block.
`default_nettype none

package ctcl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ANGLE_BITS  = 16;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int PTS_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_COMP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COMP_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_VALID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_PER_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_GAIN     = 3'd5;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } tbl_wr_t;

endpackage

`default_nettype wire

### hdl/ctcl_table.sv
// Cogging table memory: one write port, two registered read ports.
`default_nettype none

module ctcl_table (
    input  wire logic                                aclk,
    input  wire ctcl_pkg::tbl_wr_t                   wr,
    input  wire logic                                rd_en,
    input  wire logic [ctcl_pkg::IDX_W-1:0]          rd_addr0,
    input  wire logic [ctcl_pkg::IDX_W-1:0]          rd_addr1,
    output logic signed [ctcl_pkg::ENTRY_W-1:0]      rd_data0,
    output logic signed [ctcl_pkg::ENTRY_W-1:0]      rd_data1
);
    import ctcl_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while the stage behind it is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0 <= $signed(mem[rd_addr0]);
            rd_data1 <= $signed(mem[rd_addr1]);
        end
    end

endmodule

`default_nettype wire

### hdl/cogging_torque_compensation_lut.sv
// Top level: pipelined interpolated cogging compensation with table writes.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: index, value, angle, speed, iq; tuser: mode
//  m_       out  m_tvalid/m_tready    tdata: iq_target_out, comp_current; tuser: comp_active
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat per cycle sustained while m_tready holds high; eleven register
// stages, A to K, carry a compensate beat to m_. Table writes retire in stage
// three and give no output beat. Each stage has its own valid bit and stalls
// only when the stage ahead is full, so bubbles fill. aresetn (synchronous)
// clears valid bits and configuration registers; the table is not cleared and must be
// loaded before table_valid is set.
`default_nettype none
`include "cogging_torque_compensation_lut_defines.svh"

module cogging_torque_compensation_lut (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] table_index, [23:8] table_value, [39:24] mech_angle,
    // [71:40] speed_ref, [103:72] iq_target_in
    input  wire logic [103:0]                       s_tdata,
    // [0] mode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] iq_target_out, [63:32] comp_current
    output logic [63:0]                             m_tdata,
    // [0] comp_active
    output logic                                    m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ctcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ctcl_pkg::*;

    localparam int NSTG    = 11;
    localparam int POS_W   = ANGLE_BITS + PTS_W;
    localparam int PROD_W  = ANGLE_BITS + 1 + ENTRY_W + 1;
    localparam int INT_W   = ENTRY_W + 1 + ANGLE_BITS;
    localparam int RAW_W   = INT_W + 25;
    localparam int AMP_SH  = ANGLE_BITS + 8;
    localparam int AMP_W   = RAW_W - AMP_SH;
    localparam int GP_W    = AMP_W + 24;
    localparam int GAIN_SH = 16;

    localparam logic [RAW_W-1:0] AMP_HALF  = RAW_W'(1) << (AMP_SH - 1);
    localparam logic [GP_W-1:0]  GAIN_HALF = GP_W'(1) << (GAIN_SH - 1);
    localparam logic signed [GP_W-1:0] G_MAX = {{(GP_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [GP_W-1:0] G_MIN = {{(GP_W-31){1'b1}}, {31{1'b0}}};

    // ---------------- configuration registers ----------------
    logic                     comp_enable_reg;
    logic                     table_valid_reg;
    logic [PTS_W-1:0]         pts_reg;
    logic [30:0]              speed_gate_reg;
    logic [23:0]              cpc_reg;
    logic signed [23:0]       gain_reg;
    logic [8:0]               cfg_pts_raw;
    logic [PTS_W-1:0]         pts_next;

    assign cfg_ready   = 1'b1;
    assign cfg_pts_raw = cfg_data[8:0];
    assign pts_next    = (32'(cfg_pts_raw) > 32'(TABLE_DEPTH)) ? PTS_W'(TABLE_DEPTH)
                                                               : PTS_W'(cfg_pts_raw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_enable_reg <= 1'b0;
            table_valid_reg <= 1'b0;
            pts_reg         <= '0;
            speed_gate_reg  <= 31'h7FFF_FFFF;
            cpc_reg         <= '0;
            gain_reg        <= 24'sh01_0000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COMP_ENABLE:   comp_enable_reg <= cfg_data[0];
                REG_TABLE_VALID:   table_valid_reg <= cfg_data[0];
                REG_POINTS_IN_USE: pts_reg         <= pts_next;
                REG_SPEED_GATE:    speed_gate_reg  <= cfg_data[30:0];
                REG_CUR_PER_COUNT: cpc_reg         <= cfg_data[23:0];
                REG_COMP_GAIN:     gain_reg        <= $signed(cfg_data[23:0]);
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic            c_mode_reg;

    assign rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
    for (genvar g = 0; g < NSTG - 1; g++) begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end

    always_comb begin
        vld_in    = {vld_reg[NSTG-2:0], s_tvalid};
        // table writes end at the memory
        vld_in[3] = vld_reg[2] && (c_mode_reg == MODE_COMP);
    end

    assign vld_next = (rdy & vld_in) | (~rdy & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];

    // ---------------- stage A: capture ----------------
    logic               a_mode_reg;
    logic [7:0]         a_idx_reg;
    logic [15:0]        a_val_reg;
    logic [15:0]        a_ang_reg;
    logic [31:0]        a_spd_reg;
    logic signed [31:0] a_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_mode_reg <= s_tuser;
            a_idx_reg  <= s_tdata[7:0];
            a_val_reg  <= s_tdata[23:8];
            a_ang_reg  <= s_tdata[39:24];
            a_spd_reg  <= s_tdata[71:40];
            a_iq_reg   <= $signed(s_tdata[103:72]);
        end
    end

    logic [31:0]           a_spd_abs;
    logic                  a_gate;
    logic [ANGLE_BITS-1:0] a_ang;
    logic [POS_W-1:0]      a_pos;

    assign a_spd_abs = a_spd_reg[31] ? (32'd0 - a_spd_reg) : a_spd_reg;
    assign a_gate    = comp_enable_reg && table_valid_reg && (pts_reg != '0) &&
                       (a_spd_abs <= {1'b0, speed_gate_reg});
    assign a_ang     = ANGLE_BITS'(32'(a_ang_reg));
    assign a_pos     = POS_W'(a_ang) * POS_W'(pts_reg);

    // ---------------- stage B: angle times bin count ----------------
    logic               b_mode_reg;
    logic [7:0]         b_idx_reg;
    logic [15:0]        b_val_reg;
    logic [POS_W-1:0]   b_pos_reg;
    logic               b_gate_reg;
    logic signed [31:0] b_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            b_mode_reg <= a_mode_reg;
            b_idx_reg  <= a_idx_reg;
            b_val_reg  <= a_val_reg;
            b_pos_reg  <= a_pos;
            b_gate_reg <= a_gate;
            b_iq_reg   <= a_iq_reg;
        end
    end

    logic [IDX_W-1:0]      b_i0;
    logic [PTS_W-1:0]      b_i0p;
    logic [IDX_W-1:0]      b_i1;
    logic [ANGLE_BITS-1:0] b_frac;

    assign b_i0   = b_pos_reg[ANGLE_BITS +: IDX_W];
    assign b_frac = b_pos_reg[ANGLE_BITS-1:0];
    assign b_i0p  = PTS_W'(b_i0) + PTS_W'(1);
    // wrap from the last bin in use back to bin zero
    assign b_i1   = (b_i0p == pts_reg) ? '0 : IDX_W'(b_i0p);

    // ---------------- stage C: table addresses ----------------
    logic [7:0]            c_idx_reg;
    logic [15:0]           c_val_reg;
    logic [IDX_W-1:0]      c_i0_reg;
    logic [IDX_W-1:0]      c_i1_reg;
    logic [ANGLE_BITS-1:0] c_frac_reg;
    logic                  c_gate_reg;
    logic signed [31:0]    c_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            c_mode_reg <= b_mode_reg;
            c_idx_reg  <= b_idx_reg;
            c_val_reg  <= b_val_reg;
            c_i0_reg   <= b_i0;
            c_i1_reg   <= b_i1;
            c_frac_reg <= b_frac;
            c_gate_reg <= b_gate_reg;
            c_iq_reg   <= b_iq_reg;
        end
    end

    // writes and reads both happen as stage C advances, in beat order
    tbl_wr_t                    tbl_wr;
    logic signed [ENTRY_W-1:0]  tbl_v0;
    logic signed [ENTRY_W-1:0]  tbl_v1;

    always_comb begin
        tbl_wr.en   = rdy[3] && vld_reg[2] && (c_mode_reg == MODE_WRITE) &&
                      (32'(c_idx_reg) < 32'(TABLE_DEPTH));
        tbl_wr.addr = IDX_W'(32'(c_idx_reg));
        tbl_wr.data = c_val_reg;
    end

    ctcl_table u_table (
        .aclk     (aclk),
        .wr       (tbl_wr),
        .rd_en    (rdy[3]),
        .rd_addr0 (c_i0_reg),
        .rd_addr1 (c_i1_reg),
        .rd_data0 (tbl_v0),
        .rd_data1 (tbl_v1)
    );

    // ---------------- stage D: neighbor entries ----------------
    logic [ANGLE_BITS-1:0] d_frac_reg;
    logic                  d_gate_reg;
    logic signed [31:0]    d_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            d_frac_reg <= c_frac_reg;
            d_gate_reg <= c_gate_reg;
            d_iq_reg   <= c_iq_reg;
        end
    end

    logic signed [ENTRY_W:0]  d_diff;
    logic signed [PROD_W-1:0] d_prod;

    assign d_diff = {tbl_v1[ENTRY_W-1], tbl_v1} - {tbl_v0[ENTRY_W-1], tbl_v0};
    assign d_prod = $signed({1'b0, d_frac_reg}) * d_diff;

    // ---------------- stage E: fraction times slope ----------------
    logic signed [PROD_W-1:0]  e_prod_reg;
    logic signed [ENTRY_W-1:0] e_v0_reg;
    logic                      e_gate_reg;
    logic signed [31:0]        e_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            e_prod_reg <= d_prod;
            e_v0_reg   <= tbl_v0;
            e_gate_reg <= d_gate_reg;
            e_iq_reg   <= d_iq_reg;
        end
    end

    logic signed [INT_W-1:0] e_interp;

    assign e_interp = (INT_W'(e_v0_reg) <<< ANGLE_BITS) + INT_W'(e_prod_reg);

    // ---------------- stage F: interpolated counts ----------------
    logic signed [INT_W-1:0] f_interp_reg;
    logic                    f_gate_reg;
    logic signed [31:0]      f_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            f_interp_reg <= e_interp;
            f_gate_reg   <= e_gate_reg;
            f_iq_reg     <= e_iq_reg;
        end
    end

    logic signed [RAW_W-1:0] f_raw;

    assign f_raw = f_interp_reg * $signed({1'b0, cpc_reg});

    // ---------------- stage G: counts times amps per count ----------------
    logic signed [RAW_W-1:0] g_raw_reg;
    logic                    g_gate_reg;
    logic signed [31:0]      g_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            g_raw_reg  <= f_raw;
            g_gate_reg <= f_gate_reg;
            g_iq_reg   <= f_iq_reg;
        end
    end

    logic signed [RAW_W-1:0] g_neg;
    logic signed [RAW_W-1:0] g_rnd;
    logic signed [AMP_W-1:0] g_amps;

    // half minus one on negatives rounds ties away from zero
    assign g_neg  = {{(RAW_W-1){1'b0}}, g_raw_reg[RAW_W-1]};
    assign g_rnd  = g_raw_reg + $signed(AMP_HALF) - g_neg;
    assign g_amps = AMP_W'(g_rnd >>> AMP_SH);

    // ---------------- stage H: amps ----------------
    logic signed [AMP_W-1:0] h_amps_reg;
    logic                    h_gate_reg;
    logic signed [31:0]      h_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            h_amps_reg <= g_amps;
            h_gate_reg <= g_gate_reg;
            h_iq_reg   <= g_iq_reg;
        end
    end

    logic signed [GP_W-1:0] h_prod;

    assign h_prod = h_amps_reg * gain_reg;

    // ---------------- stage I: amps times gain ----------------
    logic signed [GP_W-1:0] i_prod_reg;
    logic                   i_gate_reg;
    logic signed [31:0]     i_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            i_prod_reg <= h_prod;
            i_gate_reg <= h_gate_reg;
            i_iq_reg   <= h_iq_reg;
        end
    end

    logic signed [GP_W-1:0] i_neg;
    logic signed [GP_W-1:0] i_rnd;
    logic signed [GP_W-1:0] i_sh;
    logic signed [31:0]     i_sat;
    logic signed [31:0]     i_comp;

    assign i_neg = {{(GP_W-1){1'b0}}, i_prod_reg[GP_W-1]};
    assign i_rnd = i_prod_reg + $signed(GAIN_HALF) - i_neg;
    assign i_sh  = i_rnd >>> GAIN_SH;

    always_comb begin
        priority if (i_sh > G_MAX) begin
            i_sat = 32'sh7FFF_FFFF;
        end else if (i_sh < G_MIN) begin
            i_sat = 32'sh8000_0000;
        end else begin
            i_sat = 32'(i_sh);
        end
    end

    assign i_comp = i_gate_reg ? i_sat : 32'sd0;

    // ---------------- stage J: compensation ----------------
    logic signed [31:0] j_comp_reg;
    logic               j_act_reg;
    logic signed [31:0] j_iq_reg;

    always_ff @(posedge aclk) begin
        if (rdy[9]) begin
            j_comp_reg <= i_comp;
            j_act_reg  <= i_gate_reg;
            j_iq_reg   <= i_iq_reg;
        end
    end

    logic signed [32:0] j_sum;
    logic signed [31:0] j_iq_out;

    assign j_sum = {j_iq_reg[31], j_iq_reg} + {j_comp_reg[31], j_comp_reg};

    always_comb begin
        priority if (j_sum[32] != j_sum[31]) begin
            j_iq_out = j_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            j_iq_out = j_sum[31:0];
        end
    end

    // ---------------- stage K: output register ----------------
    logic [31:0] k_iq_reg;
    logic [31:0] k_comp_reg;
    logic        k_act_reg;

    always_ff @(posedge aclk) begin
        if (rdy[10]) begin
            k_iq_reg   <= j_iq_out;
            k_comp_reg <= j_comp_reg;
            k_act_reg  <= j_act_reg;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {k_comp_reg, k_iq_reg};
    assign m_tuser  = k_act_reg;

    // ---------------- assertions ----------------
    `CTCL_ASSERT_NOW(a_full_when_blocked, !s_tready, &vld_reg, "input stalled with a bubble")
    `CTCL_ASSERT_NEXT(a_write_no_result, tbl_wr.en, !vld_reg[3], "table write made a result")
    `CTCL_ASSERT_NOW(a_idle_comp_zero, m_tvalid && !m_tuser, k_comp_reg == '0, "stray comp value")

endmodule

`default_nettype wire
